>>> design/pesh_pkg.sv
// ----------------------------------------------------------------------------
// pesh_pkg
// Shared types and constants for the PES header parser.
// ----------------------------------------------------------------------------
package pesh_pkg;

  localparam int unsigned PosW = 9;
  localparam logic [PosW-1:0] PosMax = 9'd511;
  localparam logic [PosW-1:0] PosHdrLen = 9'd8;
  localparam logic [PosW-1:0] PosPts0 = 9'd9;
  localparam logic [PosW-1:0] PosPts1 = 9'd10;
  localparam logic [PosW-1:0] PosPts2 = 9'd11;
  localparam logic [PosW-1:0] PosPts3 = 9'd12;
  localparam logic [PosW-1:0] PosPts4 = 9'd13;

  localparam logic [7:0] StartPrefix = 8'h00;
  localparam logic [7:0] StartCodeLast = 8'h01;
  localparam logic [7:0] IdPrivate1 = 8'h89;
  localparam logic [7:0] IdPrivate2 = 8'hBD;
  localparam logic [7:0] IdAudioLo = 8'hC0;
  localparam logic [7:0] IdAudioHi = 8'hDF;
  localparam logic [7:0] IdNone = 8'h00;
  localparam logic [1:0] MarkerBits = 2'b10;
  localparam logic [1:0] ClearScramble = 2'b00;
  localparam logic [8:0] HdrFixedLen = 9'd3;

  typedef enum logic [2:0] {
    ST_PENDING   = 3'd0,
    ST_OK        = 3'd1,
    ST_BADSTART  = 3'd2,
    ST_IGNORED   = 3'd3,
    ST_EXTRA     = 3'd4,
    ST_MARKER    = 3'd5,
    ST_SCRAMBLED = 3'd6,
    ST_TRUNC     = 3'd7
  } status_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        packet_start;
    logic        segment_end;
  } request_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        is_payload;
    logic        header_done;
    status_t     status;
    logic [32:0] pts_value;
    logic [15:0] remaining_length;
    logic [7:0]  accepted_stream;
  } result_t;

endpackage

>>> design/pes_header_parser.sv
// ----------------------------------------------------------------------------
// pes_header_parser
// Parses the head of an MPEG-2 PES packet from transport payload bytes.
// ----------------------------------------------------------------------------
// One byte per cycle: each request produces exactly one result in the next
// cycle, and a new request is taken every cycle while the result side is
// ready. The header state is updated in the cycle a byte is taken, so the
// single output register is the only latency. in_tuser flags the first byte
// of a PES-starting payload, in_tlast the last byte of the payload. The
// verdict (status in out_tuser) lands on the byte that decides it; bytes
// after the header of an accepted packet carry is_payload.
// ----------------------------------------------------------------------------
module pes_header_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] packet_start
  input  logic        in_tlast,   // segment_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [7:0] out_byte, [40:8] pts_value,
                                  // [56:41] remaining_length,
                                  // [64:57] accepted_stream, [71:65] zero
  output logic [4:0]  out_tuser   // [0] is_payload, [1] header_done, [4:2] status
);
  import pesh_pkg::*;

  request_t req;
  result_t  res_comb;
  result_t  res_q;
  logic     take;

  assign req.data_byte    = in_tdata;
  assign req.packet_start = in_tuser;
  assign req.segment_end  = in_tlast;
  assign take             = in_tvalid && in_tready;

  pesh_parse u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .req   (req),
    .res   (res_comb)
  );

  pesh_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .res_in    (res_comb),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res_out   (res_q)
  );

  assign out_tdata = {7'd0, res_q.accepted_stream, res_q.remaining_length,
                      res_q.pts_value, res_q.out_byte};
  assign out_tuser = {res_q.status, res_q.header_done, res_q.is_payload};

endmodule

>>> design/pesh_parse.sv
// ----------------------------------------------------------------------------
// pesh_parse
// Per-byte header state: start code, stream id, length, flags, PTS capture.
// ----------------------------------------------------------------------------
module pesh_parse (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  pesh_pkg::request_t req,
  output pesh_pkg::result_t  res
);
  import pesh_pkg::*;

  logic [PosW-1:0] pos_r, pos_nxt;
  logic [15:0]     plen_r, plen_nxt;
  logic [7:0]      hlen_r, hlen_nxt;
  logic [7:0]      flags_r, flags_nxt;
  logic [32:0]     shift_r, shift_nxt;
  logic [32:0]     pts_r, pts_nxt;
  logic [7:0]      stream_r, stream_nxt;
  logic [15:0]     remain_r, remain_nxt;
  status_t         stat_r, stat_nxt;

  logic            active;
  logic [PosW-1:0] pos_eff;
  status_t         stat_eff;
  status_t         verdict;
  logic            done;
  logic            payload;
  logic            id_ok;
  logic [8:0]      hdr_total;
  logic [9:0]      payload_start;
  logic [7:0]      b;

  assign b = req.data_byte;
  assign id_ok = (b == IdPrivate1) || (b == IdPrivate2) ||
                 ((b >= IdAudioLo) && (b <= IdAudioHi));
  assign hdr_total = HdrFixedLen + {1'b0, b};
  assign payload_start = {1'b0, PosPts0} + {2'b00, hlen_r};

  always_comb begin
    pos_nxt    = pos_r;
    plen_nxt   = plen_r;
    hlen_nxt   = hlen_r;
    flags_nxt  = flags_r;
    shift_nxt  = shift_r;
    pts_nxt    = pts_r;
    stream_nxt = stream_r;
    remain_nxt = remain_r;
    stat_nxt   = stat_r;
    verdict    = ST_PENDING;
    done       = 1'b0;
    payload    = 1'b0;

    pos_eff  = req.packet_start ? '0 : pos_r;
    stat_eff = req.packet_start ? ST_PENDING : stat_r;
    active   = req.packet_start || !((stat_r == ST_PENDING) && (pos_r == '0));
    stat_nxt = stat_eff;
    pos_nxt  = pos_eff;

    if (active) begin
      if (stat_eff == ST_PENDING) begin
        case (pos_eff)
          9'd0, 9'd1: begin
            if (b != StartPrefix) verdict = ST_BADSTART;
          end
          9'd2: begin
            if (b != StartCodeLast) verdict = ST_BADSTART;
          end
          9'd3: begin
            if (!id_ok) begin
              verdict = ST_IGNORED;
            end else if (b != stream_r) begin
              if (stream_r == IdNone) stream_nxt = b;
              else verdict = ST_EXTRA;
            end
          end
          9'd4: plen_nxt = {b, 8'h00};
          9'd5: plen_nxt = {plen_r[15:8], b};
          9'd6: begin
            if (b[7:6] != MarkerBits) verdict = ST_MARKER;
            else if (b[5:4] != ClearScramble) verdict = ST_SCRAMBLED;
          end
          9'd7: flags_nxt = b;
          default: begin
            hlen_nxt   = b;
            remain_nxt = (plen_r > {7'd0, hdr_total}) ?
                         (plen_r - {7'd0, hdr_total}) : 16'd0;
            verdict    = ST_OK;
          end
        endcase
        if (verdict != ST_PENDING) begin
          stat_nxt = verdict;
          done     = 1'b1;
        end
      end else if (stat_eff == ST_OK) begin
        payload = ({1'b0, pos_eff} >= payload_start);
        if (pos_eff == PosPts0) begin
          shift_nxt = {30'd0, b[3:1]};
        end else if (pos_eff == PosPts1 || pos_eff == PosPts3) begin
          shift_nxt = {shift_r[24:0], b};
        end else if (pos_eff == PosPts2 || pos_eff == PosPts4) begin
          shift_nxt = {shift_r[25:0], b[7:1]};
          if (pos_eff == PosPts4 && flags_r[7]) pts_nxt = {shift_r[25:0], b[7:1]};
        end
      end
      if (req.segment_end && stat_nxt == ST_PENDING) begin
        stat_nxt = ST_TRUNC;
        done     = 1'b1;
      end
      if (pos_eff < PosMax) pos_nxt = pos_eff + 9'd1;
    end

    res.out_byte         = b;
    res.is_payload       = payload;
    res.header_done      = done;
    res.status           = active ? stat_nxt : ST_PENDING;
    res.pts_value        = pts_nxt;
    res.remaining_length = remain_nxt;
    res.accepted_stream  = stream_nxt;

    if (req.segment_end) begin
      stat_nxt = ST_PENDING;
      pos_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      plen_r   <= '0;
      hlen_r   <= '0;
      flags_r  <= '0;
      shift_r  <= '0;
      pts_r    <= '0;
      stream_r <= IdNone;
      remain_r <= '0;
      stat_r   <= ST_PENDING;
    end else if (take) begin
      pos_r    <= pos_nxt;
      plen_r   <= plen_nxt;
      hlen_r   <= hlen_nxt;
      flags_r  <= flags_nxt;
      shift_r  <= shift_nxt;
      pts_r    <= pts_nxt;
      stream_r <= stream_nxt;
      remain_r <= remain_nxt;
      stat_r   <= stat_nxt;
    end
  end

endmodule

>>> design/pesh_out_reg.sv
// ----------------------------------------------------------------------------
// pesh_out_reg
// Result register with stream handshake; accepts a new request every cycle
// the downstream side drains.
// ----------------------------------------------------------------------------
module pesh_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pesh_pkg::result_t res_in,
  output logic              out_valid,
  input  logic              out_ready,
  output pesh_pkg::result_t res_out
);
  import pesh_pkg::*;

  logic    valid_r, valid_nxt;
  result_t data_r;

  assign in_ready  = !valid_r || out_ready;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !out_ready);
  assign out_valid = valid_r;
  assign res_out   = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= res_in;
    end
  end

endmodule

>>> sim/pes_header_check.sv
// ----------------------------------------------------------------------------
// pes_header_check
// Watches both streams of the PES header parser. Each accepted request is run
// through a cycle-free model of the parser, and the predicted result is queued
// and compared field by field with the next result the parser delivers.
// ----------------------------------------------------------------------------
module pes_header_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,
  input  logic [4:0]  out_tuser,
  output int          fail_count,
  output int          pending
);

  timeunit 1ns;
  timeprecision 1ps;

  import pesh_pkg::*;

  logic [8:0]  pos;
  logic [15:0] pkt_len;
  logic [7:0]  hdr_len;
  logic [7:0]  flags;
  logic [32:0] pts_acc;
  logic [32:0] pts_kept;
  logic [7:0]  latched_id;
  logic [15:0] remain;
  status_t     parse_st;

  result_t parsed_byte_q[$];

  function automatic status_t stream_verdict(logic [7:0] id);
    logic allowed;
    allowed = id == IdPrivate1 || id == IdPrivate2 || (id >= IdAudioLo && id <= IdAudioHi);
    if (!allowed) return ST_IGNORED;
    if (id == latched_id) return ST_PENDING;
    if (latched_id == IdNone) begin
      latched_id = id;
      return ST_PENDING;
    end
    return ST_EXTRA;
  endfunction

  function automatic result_t parse_byte(request_t rq);
    result_t    r;
    logic       active;
    status_t    verdict;
    logic [15:0] hdr_total;
    logic [7:0] b;
    r = '0;
    b = rq.data_byte;
    active = 1'b1;
    if (rq.packet_start) begin
      pos = '0;
      parse_st = ST_PENDING;
    end else if (parse_st == ST_PENDING && pos == '0) begin
      active = 1'b0;
    end
    if (active) begin
      verdict = ST_PENDING;
      if (parse_st == ST_PENDING) begin
        case (pos)
          9'd0, 9'd1: if (b != StartPrefix) verdict = ST_BADSTART;
          9'd2: if (b != StartCodeLast) verdict = ST_BADSTART;
          9'd3: verdict = stream_verdict(b);
          9'd4: pkt_len = {b, 8'h00};
          9'd5: pkt_len[7:0] = b;
          9'd6: begin
            if (b[7:6] != MarkerBits) verdict = ST_MARKER;
            else if (b[5:4] != ClearScramble) verdict = ST_SCRAMBLED;
          end
          9'd7: flags = b;
          default: begin
            hdr_len = b;
            hdr_total = 16'(HdrFixedLen) + 16'(b);
            remain = (pkt_len > hdr_total) ? pkt_len - hdr_total : '0;
            verdict = ST_OK;
          end
        endcase
        if (verdict != ST_PENDING) begin
          parse_st = verdict;
          r.header_done = 1'b1;
        end
      end else if (parse_st == ST_OK) begin
        if ({1'b0, pos} >= 10'(PosPts0) + 10'(hdr_len)) r.is_payload = 1'b1;
        case (pos)
          PosPts0: pts_acc = 33'(b[3:1]);
          PosPts1, PosPts3: pts_acc = {pts_acc[24:0], b};
          PosPts2, PosPts4: begin
            pts_acc = {pts_acc[25:0], b[7:1]};
            if (pos == PosPts4 && flags[7]) pts_kept = pts_acc;
          end
          default: ;
        endcase
      end
      if (rq.segment_end && parse_st == ST_PENDING) begin
        parse_st = ST_TRUNC;
        r.header_done = 1'b1;
      end
      if (pos < PosMax) pos++;
    end
    r.status = active ? parse_st : ST_PENDING;
    if (rq.segment_end) begin
      parse_st = ST_PENDING;
      pos = '0;
    end
    r.out_byte = b;
    r.pts_value = pts_kept;
    r.remaining_length = remain;
    r.accepted_stream = latched_id;
    return r;
  endfunction

  task automatic check_field(string name, logic [32:0] want, logic [32:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    result_t  got;
    result_t  want;
    request_t rq;
    if (!rst_n) begin
      pos = '0;
      pkt_len = '0;
      hdr_len = '0;
      flags = '0;
      pts_acc = '0;
      pts_kept = '0;
      latched_id = IdNone;
      remain = '0;
      parse_st = ST_PENDING;
      parsed_byte_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.out_byte = out_tdata[7:0];
        got.pts_value = out_tdata[40:8];
        got.remaining_length = out_tdata[56:41];
        got.accepted_stream = out_tdata[64:57];
        got.is_payload = out_tuser[0];
        got.header_done = out_tuser[1];
        got.status = status_t'(out_tuser[4:2]);
        if (parsed_byte_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %h/%h",
                   $time, out_tdata, out_tuser);
          fail_count++;
        end else begin
          want = parsed_byte_q.pop_front();
          check_field("out_byte", 33'(want.out_byte), 33'(got.out_byte));
          check_field("is_payload", 33'(want.is_payload), 33'(got.is_payload));
          check_field("header_done", 33'(want.header_done), 33'(got.header_done));
          check_field("status", 33'(want.status), 33'(got.status));
          check_field("pts_value", want.pts_value, got.pts_value);
          check_field("remaining_length", 33'(want.remaining_length),
                      33'(got.remaining_length));
          check_field("accepted_stream", 33'(want.accepted_stream),
                      33'(got.accepted_stream));
        end
      end
      if (in_tvalid && in_tready) begin
        rq.data_byte = in_tdata;
        rq.packet_start = in_tuser;
        rq.segment_end = in_tlast;
        parsed_byte_q.push_back(parse_byte(rq));
      end
    end
    pending = parsed_byte_q.size();
  end

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Byte-stream test of the PES header parser: a few hand-built segments for
// the corner verdicts, then random segments, mostly well-formed packet heads
// with random content, mixed with restarts, cut and corrupted heads and
// stray bytes. Both sides idle at random; the receiver stalls once for long.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import pesh_pkg::*;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [71:0] out_tdata;
  logic [4:0]  out_tuser;
  int          fail_count;
  int          pending;

  request_t seg_q[$];
  int       bytes_sent = 0;
  logic     quiet = 1'b0;
  logic     hold_req = 1'b0;
  logic     long_pending = 1'b0;
  int       stuck_cycles = 0;

  pes_header_parser uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  pes_header_check checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void push_byte(logic [7:0] b, logic start, logic last);
    request_t rq;
    rq.data_byte = b;
    rq.packet_start = start;
    rq.segment_end = last;
    seg_q.push_back(rq);
  endfunction

  function automatic void add_packet();
    int          r;
    int          nbody;
    logic [7:0]  sid;
    logic [15:0] plen;
    logic [7:0]  b6;
    logic [7:0]  hlen;
    r = $urandom_range(99);
    if (r < 65) sid = IdAudioLo;
    else if (r < 72) sid = IdPrivate1;
    else if (r < 79) sid = IdPrivate2;
    else if (r < 88) sid = IdAudioLo + 8'($urandom_range(31));
    else sid = 8'($urandom_range(255));
    plen = ($urandom_range(99) < 70) ? 16'($urandom_range(40)) : 16'($urandom);
    r = $urandom_range(99);
    if (r < 80) b6 = {MarkerBits, ClearScramble, 4'($urandom)};
    else if (r < 90) b6 = {MarkerBits, 2'($urandom_range(1, 3)), 4'($urandom)};
    else b6 = 8'($urandom);
    hlen = ($urandom_range(99) < 85) ? 8'($urandom_range(10)) : 8'($urandom);
    nbody = long_pending ? 520 : $urandom_range(24);
    long_pending = 1'b0;
    push_byte(StartPrefix, 1'b1, 1'b0);
    push_byte(StartPrefix, 1'b0, 1'b0);
    push_byte(StartCodeLast, 1'b0, 1'b0);
    push_byte(sid, 1'b0, 1'b0);
    push_byte(plen[15:8], 1'b0, 1'b0);
    push_byte(plen[7:0], 1'b0, 1'b0);
    push_byte(b6, 1'b0, 1'b0);
    push_byte({1'($urandom_range(99) < 70), 7'($urandom)}, 1'b0, 1'b0);
    push_byte(hlen, 1'b0, 1'b0);
    repeat (nbody) push_byte(8'($urandom), 1'b0, 1'b0);
  endfunction

  function automatic logic build_segment();
    int r;
    int keep;
    int idx;
    r = $urandom_range(99);
    if (r < 10) begin
      repeat ($urandom_range(1, 8)) push_byte(8'($urandom), $urandom_range(99) < 20, 1'b0);
      seg_q[$].segment_end = 1'b1;
      return 1'b1;
    end
    add_packet();
    r = $urandom_range(99);
    if (r < 10) begin
      add_packet();
    end else if (r < 20) begin
      keep = $urandom_range(1, 8);
      while (seg_q.size() > keep) void'(seg_q.pop_back());
    end else if (r < 28) begin
      idx = $urandom_range(2);
      seg_q[idx].data_byte ^= 8'($urandom_range(1, 255));
    end
    seg_q[$].segment_end = 1'b1;
    return 1'b0;
  endfunction

  task automatic send_segment();
    request_t rq;
    while (seg_q.size() != 0) begin
      rq = seg_q.pop_front();
      while (!quiet && $urandom_range(99) < 11) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata <= rq.data_byte;
      in_tuser <= rq.packet_start;
      in_tlast <= rq.segment_end;
      do @(posedge clk); while (!in_tready);
    end
  endtask

  initial begin
    logic noise;
    int   n;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_byte(8'hFF, 1'b0, 1'b1);
    push_byte(8'h05, 1'b1, 1'b1);
    push_byte(StartPrefix, 1'b1, 1'b0);
    push_byte(StartPrefix, 1'b0, 1'b1);
    push_byte(StartPrefix, 1'b1, 1'b0);
    push_byte(StartPrefix, 1'b0, 1'b0);
    push_byte(StartCodeLast, 1'b0, 1'b0);
    push_byte(IdNone, 1'b0, 1'b1);
    push_byte(StartPrefix, 1'b1, 1'b0);
    push_byte(StartPrefix, 1'b0, 1'b0);
    push_byte(StartCodeLast, 1'b0, 1'b0);
    push_byte(IdAudioLo, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte({MarkerBits, ClearScramble, 4'hF}, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'h05, 1'b0, 1'b0);
    repeat (5) push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b1);
    bytes_sent += seg_q.size();
    send_segment();

    while (bytes_sent < 1700) begin
      if (bytes_sent >= 600) hold_req <= 1'b1;
      quiet = bytes_sent >= 1000 && bytes_sent < 1300;
      if (bytes_sent >= 1100 && bytes_sent < 1150) long_pending = 1'b1;
      noise = build_segment();
      n = seg_q.size();
      send_segment();
      if (!noise) bytes_sent += n;
    end
    in_tvalid <= 1'b0;
    quiet = 1'b0;

    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    logic hold_taken;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      out_tready <= quiet || $urandom_range(99) >= 11;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= 2000) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

endmodule
